// File: sv/prn_pkg.sv
`timescale 1ns / 1ps

package prn_pkg;

    localparam int unsigned DATA_W = 64;
    localparam int unsigned ADDR_W = 4;
    localparam int unsigned STAGES = 11;

    // register byte offsets
    localparam logic [ADDR_W-1:0] ADDR_WHITENING_KEY = 4'h0;
    localparam logic [ADDR_W-1:0] ADDR_CORE_KEY      = 4'h8;

    localparam logic [63:0] ALPHA = 64'hdd05_c79c_7b92_ca0c;

    // round constants, byte i in bits 8i+7..8i
    localparam logic [63:0] RC [12] = '{
        64'h0000_0000_0000_0000,
        64'h4437_0730_e2a8_9131,
        64'h0d13_f992_2283_904a,
        64'h98c6_e4ce_89af_e280,
        64'h7731_0d83_6e12_8254,
        64'hc6c0_9e43_fc66_45eb,
        64'h1bc5_59df_87f4_8fe7,
        64'haa34_ca1f_1580_4858,
        64'h45c3_2352_f23d_288c,
        64'hd016_3e0e_5911_5a46,
        64'h9932_c0ac_993a_5b3d,
        64'hdd05_c79c_7b92_ca0c
    };

    localparam logic [3:0] SBOX_FWD [16] = '{
        4'hB, 4'hF, 4'h3, 4'h2, 4'hA, 4'hC, 4'h9, 4'h1,
        4'h6, 4'h7, 4'h8, 4'h0, 4'hE, 4'h5, 4'hD, 4'h4
    };
    localparam logic [3:0] SBOX_INV [16] = '{
        4'hB, 4'h7, 4'h3, 4'h2, 4'hF, 4'hD, 4'h8, 4'h9,
        4'hA, 4'h6, 4'h4, 4'h0, 4'h5, 4'hE, 4'hC, 4'h1
    };

    // nibble moves of the row shift: low nibble from SR_LO, high from SR_HI/ISR_HI
    localparam logic [2:0] SR_LO  [8] = '{3'd0, 3'd5, 3'd2, 3'd7, 3'd4, 3'd1, 3'd6, 3'd3};
    localparam logic [2:0] SR_HI  [8] = '{3'd2, 3'd7, 3'd4, 3'd1, 3'd6, 3'd3, 3'd0, 3'd5};
    localparam logic [2:0] ISR_HI [8] = '{3'd6, 3'd3, 3'd0, 3'd5, 3'd2, 3'd7, 3'd4, 3'd1};

    // M' masks for outer (pairs 0 and 3) and inner (pairs 1 and 2) blocks
    localparam logic [7:0] M_OUT = 8'hD7;
    localparam logic [7:0] N_OUT = 8'h7D;
    localparam logic [3:0] P_OUT = 4'hB;
    localparam logic [3:0] Q_OUT = 4'hE;
    localparam logic [7:0] M_IN  = 8'hEB;
    localparam logic [7:0] N_IN  = 8'hBE;
    localparam logic [3:0] P_IN  = 4'hD;
    localparam logic [3:0] Q_IN  = 4'h7;

    typedef logic [63:0] t_block;

    function automatic t_block sub_layer(input t_block s, input logic inv);
        t_block t;
        for (int i = 0; i < 16; i++) begin
            t[4*i +: 4] = inv ? SBOX_INV[s[4*i +: 4]] : SBOX_FWD[s[4*i +: 4]];
        end
        return t;
    endfunction

    function automatic logic [7:0] mix(input logic [7:0] x, input logic [7:0] y,
                                       input logic [7:0] m, input logic [7:0] n,
                                       input logic [3:0] p, input logic [3:0] q);
        return (x & m) ^ (y & n)
             ^ {4'h0, x[7:4] & p} ^ {4'h0, y[7:4] & q}
             ^ {x[3:0] & p, 4'h0} ^ {y[3:0] & q, 4'h0};
    endfunction

    function automatic t_block mprime(input t_block s);
        t_block     t;
        logic [7:0] a;
        logic [7:0] b;
        logic       outer;
        for (int k = 0; k < 4; k++) begin
            a     = s[16*k +: 8];
            b     = s[16*k+8 +: 8];
            outer = (k == 0) || (k == 3);
            if (outer) begin
                t[16*k +: 8]   = mix(a, b, M_OUT, N_OUT, P_OUT, Q_OUT);
                t[16*k+8 +: 8] = mix(b, a, M_OUT, N_OUT, P_OUT, Q_OUT);
            end else begin
                t[16*k +: 8]   = mix(a, b, M_IN, N_IN, P_IN, Q_IN);
                t[16*k+8 +: 8] = mix(b, a, M_IN, N_IN, P_IN, Q_IN);
            end
        end
        return t;
    endfunction

    function automatic t_block shift_rows(input t_block s, input logic inv);
        t_block t;
        int     lo_b;
        int     hi_b;
        for (int i = 0; i < 8; i++) begin
            lo_b = int'(SR_LO[i]);
            hi_b = inv ? int'(ISR_HI[i]) : int'(SR_HI[i]);
            t[8*i +: 4]   = s[8*lo_b +: 4];
            t[8*i+4 +: 4] = s[8*hi_b+4 +: 4];
        end
        return t;
    endfunction

    function automatic t_block fwd_round(input t_block s, input t_block rc, input t_block k1);
        return shift_rows(mprime(sub_layer(s, 1'b0)), 1'b0) ^ rc ^ k1;
    endfunction

    function automatic t_block mid_layer(input t_block s);
        return sub_layer(mprime(sub_layer(s, 1'b0)), 1'b1);
    endfunction

    function automatic t_block inv_round(input t_block s, input t_block rc, input t_block k1);
        return sub_layer(mprime(shift_rows(s ^ k1 ^ rc, 1'b1)), 1'b1);
    endfunction

endpackage

// File: sv/prn_if.sv
`timescale 1ns / 1ps

interface prn_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [63:0] block_in;

    modport source (output valid, output mode, output block_in, input ready);
    modport sink   (input valid, input mode, input block_in, output ready);
endinterface

interface prn_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] block_out;

    modport source (output valid, output block_out, input ready);
    modport sink   (input valid, input block_out, output ready);
endinterface

// File: sv/prince_block_cipher.sv
`timescale 1ns / 1ps

// PRINCE block cipher, 64-bit block, 128-bit key (k0 at 0x0, k1 at 0x8).
// Input channel i_blk carries mode (0 encrypt, 1 decrypt) and block_in;
// output channel o_blk carries block_out. A transaction completes when
// valid and ready are both high at a rising clock edge.
// Keys are written over the APB port (64-bit data, pready tied high);
// the user must write them only while no transaction is in flight;
// the block does not enforce this. Reads return the stored key half.
// Datapath: 11 register stages, one PRINCE round per stage (input
// whitening folded into the first, output whitening into the last, the
// middle layer in stage 6); one block is accepted every cycle while
// i_blk.ready is high. When o_blk.ready is low the pipeline compresses:
// stages behind a bubble keep moving and i_blk.ready drops only once
// all 11 stages hold data. Nothing is dropped or repeated under a stall.
// Reset (i_rst_n low at a clock edge) empties the pipeline and clears
// both key halves to zero.
module prince_block_cipher (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    prn_in_if.sink                        i_blk,
    prn_out_if.source                     o_blk,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [prn_pkg::ADDR_W-1:0]    paddr,
    input  logic [prn_pkg::DATA_W-1:0]    pwdata,
    output logic [prn_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    logic [63:0] r_k0;
    logic [63:0] r_k1;
    logic [63:0] w_kp;

    logic [63:0] r_data  [1:prn_pkg::STAGES];
    logic        r_valid [1:prn_pkg::STAGES];
    logic        r_mode  [1:prn_pkg::STAGES-1];
    logic        w_rdy   [1:prn_pkg::STAGES+1];

    // config port
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k0 <= '0;
            r_k1 <= '0;
        end else if (psel && penable && pwrite) begin
            if (paddr[3] == prn_pkg::ADDR_CORE_KEY[3]) begin
                r_k1 <= pwdata;
            end else begin
                r_k0 <= pwdata;
            end
        end
    end

    always_comb begin
        prdata = (paddr[3] == prn_pkg::ADDR_CORE_KEY[3]) ? r_k1 : r_k0;
    end

    // P(k0) = ror1(k0) ^ (k0 >> 63)
    assign w_kp = {r_k0[0], r_k0[63:1]} ^ {63'h0, r_k0[63]};

    assign w_rdy[prn_pkg::STAGES+1] = o_blk.ready;
    assign i_blk.ready = w_rdy[1];
    assign o_blk.valid = r_valid[prn_pkg::STAGES];
    assign o_blk.block_out = r_data[prn_pkg::STAGES];

    for (genvar s = 1; s <= prn_pkg::STAGES; s++) begin : g_stage
        logic [63:0] w_in;
        logic        w_vin;
        logic        w_min;
        logic [63:0] w_k1;
        logic [63:0] w_nxt;

        if (s == 1) begin : g_src_in
            assign w_in  = i_blk.block_in;
            assign w_vin = i_blk.valid;
            assign w_min = i_blk.mode;
        end else begin : g_src_reg
            assign w_in  = r_data[s-1];
            assign w_vin = r_valid[s-1];
            assign w_min = r_mode[s-1];
        end

        assign w_k1  = r_k1 ^ (w_min ? prn_pkg::ALPHA : 64'h0);
        assign w_rdy[s] = !r_valid[s] || w_rdy[s+1];

        if (s == 1) begin : g_first
            assign w_nxt = prn_pkg::fwd_round(
                w_in ^ (w_min ? w_kp : r_k0) ^ w_k1 ^ prn_pkg::RC[0],
                prn_pkg::RC[1], w_k1);
        end else if (s <= 5) begin : g_fwd
            assign w_nxt = prn_pkg::fwd_round(w_in, prn_pkg::RC[s], w_k1);
        end else if (s == 6) begin : g_mid
            assign w_nxt = prn_pkg::mid_layer(w_in);
        end else if (s < prn_pkg::STAGES) begin : g_inv
            assign w_nxt = prn_pkg::inv_round(w_in, prn_pkg::RC[s-1], w_k1);
        end else begin : g_last
            assign w_nxt = prn_pkg::inv_round(w_in, prn_pkg::RC[s-1], w_k1)
                         ^ prn_pkg::RC[11] ^ w_k1 ^ (w_min ? r_k0 : w_kp);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (w_rdy[s]) begin
                r_valid[s] <= w_vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdy[s] && w_vin) begin
                r_data[s] <= w_nxt;
            end
        end

        if (s < prn_pkg::STAGES) begin : g_mode
            always_ff @(posedge i_clk) begin
                if (w_rdy[s] && w_vin) begin
                    r_mode[s] <= w_min;
                end
            end
        end
    end

endmodule

// File: sv/prn_checker.sv
`timescale 1ns / 1ps

module prn_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_out_block
);

    // consecutive cycles out of reset with the receiver ready
    logic [3:0] r_run;
    logic [3:0] n_run;

    always_comb begin
        if (!(i_rst_n && i_out_ready)) begin
            n_run = 4'd0;
        end else if (r_run == 4'hF) begin
            n_run = r_run;
        end else begin
            n_run = r_run + 4'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_run <= n_run;
    end

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid right after reset");

    a_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output transaction withdrawn while stalled");

    a_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_block))
        else $error("output block changed while stalled");

    // input backpressure only while the output holds a valid block that is stalled
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid && !i_out_ready)
        else $error("input stalled without output stall");

    // with no stall, a block that went in shows up as a valid output block
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_in_valid && i_in_ready && i_rst_n, 11) && (r_run >= 4'd10)
        |-> i_out_valid)
        else $error("block missing at fixed latency");

endmodule

bind prince_block_cipher prn_checker u_prn_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_blk.valid),
    .i_in_ready  (i_blk.ready),
    .i_out_valid (o_blk.valid),
    .i_out_ready (o_blk.ready),
    .i_out_block (o_blk.block_out)
);
